// ===== hdl/lkv_pkg.sv =====
// lkv_pkg: shared types, sizes and codes for the lru key/value cache
// used by lkv_ctrl, lkv_datapath and the top level, depends on nothing
`timescale 1ns / 1ps

package lkv_pkg;

  // store geometry
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // field widths
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // request codes
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef struct packed {
    logic                    action;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // take the request, clear scan trackers
    logic issue;   // read the next tag
    logic look;    // read victim key and found value
    logic commit;  // write back and load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // last tag read is being issued
    logic out_free;   // output register can take a result
  } sts_t;

endpackage

// ===== hdl/lkv_ram.sv =====
// lkv_ram: generic single write port, single read port ram with registered read
// stand-alone, no package needed
`timescale 1ns / 1ps

module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // identity on the address, kept as a function so both ports index alike
  function automatic logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_sel(
    input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] a
  );
    return a;
  endfunction

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[raddr_sel(waddr_i)] <= wdata_i;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_sel(raddr_i)];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/lkv_ctrl.sv =====
// lkv_ctrl: request sequencer of the lru key/value cache
// depends on lkv_pkg for the command and status structs
`timescale 1ns / 1ps

module lkv_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lkv_pkg::sts_t sts_i,
  output lkv_pkg::cmd_t cmd_o
);
  import lkv_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_LOOK  = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_LOOK;
      end
      ST_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/lkv_datapath.sv =====
// lkv_datapath: tag scan, recency ranks, key/value stores and output register
// depends on lkv_pkg and lkv_ram
`timescale 1ns / 1ps

module lkv_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lkv_pkg::cmd_t             cmd_i,
  output lkv_pkg::sts_t             sts_o,
  input  lkv_pkg::in_item_t         in_data_i,
  input  logic                      cfg_we_i,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_data_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output lkv_pkg::out_item_t        out_data_o
);
  import lkv_pkg::*;

  // request and configuration
  in_item_t          req_q;
  logic [CAP_W-1:0]  cap_q;
  logic [CNT_W-1:0]  occ_q, occ_d;

  // per-entry state
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IDX_W-1:0]   rank_q [ENTRIES];
  logic [IDX_W-1:0]   rank_d [ENTRIES];

  // scan trackers
  logic [IDX_W-1:0] scan_idx_q;
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             hit_q, any_q, free_found_q;
  logic [IDX_W-1:0] found_q, victim_q, free_q, best_q;

  // output register
  logic      out_valid_q;
  out_item_t out_q, out_d;

  // ram ports
  logic             key_we, val_we, key_re;
  logic [IDX_W-1:0] key_waddr, val_waddr, key_raddr;
  logic [KEY_W-1:0] key_rdata;
  logic [VAL_W-1:0] val_rdata;

  // commit decisions
  logic [CMP_W-1:0] cap_ext, eff_cap;
  logic             evict, is_put, put_miss;
  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] found_rank;
  logic             cmp_valid;

  assign is_put   = (req_q.action == ACT_PUT);
  assign put_miss = is_put && !hit_q;

  // capacity clamped to 1..ENTRIES
  always_comb begin
    cap_ext = CMP_W'(cap_q);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign evict = (CMP_W'(occ_q) >= eff_cap) && (occ_q != '0);

  // new key goes to the lowest free slot, counting the victim as free
  always_comb begin
    if (evict) begin
      slot = (free_found_q && (free_q < victim_q)) ? free_q : victim_q;
    end else begin
      slot = free_q;
    end
  end

  // tag store
  assign key_we    = cmd_i.commit && put_miss;
  assign key_waddr = slot;
  assign key_re    = cmd_i.issue || cmd_i.look;
  assign key_raddr = cmd_i.look ? victim_q : scan_idx_q;

  lkv_ram #(
    .WIDTH (KEY_W),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (KEY_W'(req_q.key)),
    .re_i    (key_re),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  // value store
  assign val_we    = cmd_i.commit && is_put;
  assign val_waddr = hit_q ? found_q : slot;

  lkv_ram #(
    .WIDTH (VAL_W),
    .DEPTH (ENTRIES)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (VAL_W'(req_q.value)),
    .re_i    (cmd_i.look),
    .raddr_i (found_q),
    .rdata_o (val_rdata)
  );

  // request and capacity registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // scan counter and compare stage
  assign cmp_valid = valid_q[cmp_idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q   <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      hit_q        <= 1'b0;
      any_q        <= 1'b0;
      free_found_q <= 1'b0;
      found_q      <= '0;
      victim_q     <= '0;
      free_q       <= '0;
      best_q       <= '0;
    end else begin
      cmp_vld_q <= cmd_i.issue;
      cmp_idx_q <= scan_idx_q;
      if (cmd_i.load) begin
        scan_idx_q   <= '0;
        hit_q        <= 1'b0;
        any_q        <= 1'b0;
        free_found_q <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          scan_idx_q <= scan_idx_q + IDX_W'(1);
        end
        if (cmp_vld_q) begin
          if (cmp_valid && !hit_q && (key_rdata == KEY_W'(req_q.key))) begin
            hit_q   <= 1'b1;
            found_q <= cmp_idx_q;
          end
          if (cmp_valid && (!any_q || (rank_q[cmp_idx_q] > best_q))) begin
            any_q    <= 1'b1;
            best_q   <= rank_q[cmp_idx_q];
            victim_q <= cmp_idx_q;
          end
          if (!cmp_valid && !free_found_q) begin
            free_found_q <= 1'b1;
            free_q       <= cmp_idx_q;
          end
        end
      end
    end
  end

  assign sts_o.scan_last = (scan_idx_q == IDX_W'(ENTRIES - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // recency and valid update at commit
  assign found_rank = rank_q[found_q];

  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (cmd_i.commit) begin
      if (hit_q) begin
        // hit on get or put: younger entries age by one
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == found_q) begin
            rank_d[i] = '0;
          end else if (valid_q[i] && (rank_q[i] < found_rank)) begin
            rank_d[i] = rank_q[i] + IDX_W'(1);
          end
        end
      end else if (is_put) begin
        // insert, after dropping the victim when full
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == slot) begin
            valid_d[i] = 1'b1;
            rank_d[i]  = '0;
          end else if (evict && (IDX_W'(i) == victim_q)) begin
            valid_d[i] = 1'b0;
            rank_d[i]  = '0;
          end else if (valid_q[i]) begin
            rank_d[i] = rank_q[i] + IDX_W'(1);
          end
        end
        if (!evict) begin
          occ_d = occ_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // result assembly
  always_comb begin
    out_d.hit         = hit_q;
    out_d.evicted     = put_miss && evict;
    out_d.evicted_key = (put_miss && evict) ? $signed(key_rdata) : '0;
    if (is_put) begin
      out_d.read_value = '0;
    end else if (hit_q) begin
      out_d.read_value = $signed(val_rdata);
    end else begin
      out_d.read_value = '1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/lru_key_value_cache.sv =====
// lru_key_value_cache: top level of the fully associative lru key/value cache
// depends on lkv_pkg, lkv_ctrl, lkv_datapath and lkv_ram
`timescale 1ns / 1ps

// Usage
// - in channel (in_valid_i/in_ready_o/in_data_i): one get or put transaction.
//   in_ready_o is high only while no request is in progress.
// - out channel (out_valid_o/out_ready_i/out_data_o): exactly one result per
//   request, in request order, held in an output register until taken.
// - cfg channel (cfg_valid_i/cfg_ready_o/cfg_data_i): writes the capacity;
//   always ready, to be used only while the cache is idle.
// Sequence
// - the result is registered after the request transaction: tag reads over
//   all 16 entries (one tag ram read per cycle), the last compare, one read
//   of the victim key and found value, then write-back.
// - a new request is taken in the cycle after write-back, not before; the tag
//   scan over all 16 entries takes most of the time of each request.
// Reset
// - all entries invalid, occupancy zero, capacity 16; no clearing pass.
// Stall
// - a result waiting in the output register does not block the next scan;
//   write-back waits until the output register is free.

module lru_key_value_cache (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  lkv_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output lkv_pkg::out_item_t        out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_data_i
);
  import lkv_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  // capacity writes are always taken
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // sequencer
  lkv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // stores, scan and result
  lkv_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
